### rtl/lexer_input_buffer_with_histogram_defines.svh
// ----------------------------------------------------------------------------
// Lexer input buffer assertion macros
// Concurrent check wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LEXER_INPUT_BUFFER_WITH_HISTOGRAM_DEFINES_SVH
`define LEXER_INPUT_BUFFER_WITH_HISTOGRAM_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define LIBH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lexer buffer check failed");
// next-cycle implication
`define LIBH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lexer buffer check failed");
// invariant
`define LIBH_ASSERT_ALW(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lexer buffer check failed");
`else
`define LIBH_ASSERT_IMP(lbl, ante, cons)
`define LIBH_ASSERT_NXT(lbl, ante, cons)
`define LIBH_ASSERT_ALW(lbl, cond)
`endif

`endif

### rtl/libh_pkg.sv
// ----------------------------------------------------------------------------
// Lexer input buffer package
// Sizes, command codes, bracket characters and inter-module request types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package libh_pkg;

	localparam int CAPACITY = 4096;
	localparam int ALPHABET = 128;

	localparam int POS_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CHAR_W = $clog2(ALPHABET);
	localparam int BYTE_W = 8;
	localparam int HIST_W = 24;
	localparam int ERR_W  = 16;
	localparam int SUM_W  = 32;
	localparam int BAL_W  = 4;

	localparam logic [HIST_W-1:0] HIST_MAX   = '1;
	localparam logic [ERR_W-1:0]  ERR_MAX    = '1;
	localparam logic [POS_W-1:0]  FILL_RESET = POS_W'(CAPACITY);

	typedef enum logic [2:0] {
		CMD_ADD     = 3'd0,
		CMD_GET     = 3'd1,
		CMD_RETRACT = 3'd2,
		CMD_RESTORE = 3'd3,
		CMD_SETMARK = 3'd4,
		CMD_RECOVER = 3'd5,
		CMD_CLEAR   = 3'd6,
		CMD_QUERY   = 3'd7
	} cmd_t;

	// tracked bracket and quote characters
	localparam int NUM_SPEC = 7;
	localparam int SP_LSQ   = 0;
	localparam int SP_RSQ   = 1;
	localparam int SP_LPAR  = 2;
	localparam int SP_RPAR  = 3;
	localparam int SP_QUOTE = 4;
	localparam int SP_LCUR  = 5;
	localparam int SP_RCUR  = 6;

	localparam logic [CHAR_W-1:0] SPEC_CHARS [NUM_SPEC] = '{
		CHAR_W'(8'h5B), CHAR_W'(8'h5D), CHAR_W'(8'h28), CHAR_W'(8'h29),
		CHAR_W'(8'h22), CHAR_W'(8'h7B), CHAR_W'(8'h7D)
	};

	typedef struct packed {
		logic              rd_en;
		logic [CHAR_W-1:0] rd_addr;
		logic              we;
		logic [CHAR_W-1:0] wr_addr;
		logic [HIST_W-1:0] wr_data;
	} hist_req_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} store_req_t;

endpackage

`default_nettype wire

### rtl/libh_store.sv
// ----------------------------------------------------------------------------
// Lexer character store
// Single write port, single registered read port; contents undefined at reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module libh_store
	import libh_pkg::*;
(
	input  wire logic              clk,
	input  wire store_req_t        req,
	output      logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem [CAPACITY];
	logic [CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		if (req.re)
			rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/libh_hist.sv
// ----------------------------------------------------------------------------
// Lexer character histogram
// Count memory read at accept, written back on advance with bypass;
// valid bits give zero for untouched entries; bracket counts kept aside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module libh_hist
	import libh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hist_req_t         req,
	output      logic [HIST_W-1:0] count,
	output      logic [BAL_W-1:0]  unbalanced
);

	logic [HIST_W-1:0]   mem [ALPHABET];
	logic [HIST_W-1:0]   rd_data_s1;
	logic [HIST_W-1:0]   fwd_val_s1;
	logic                vld_s1;
	logic                fwd_s1;
	logic [ALPHABET-1:0] vld_q;
	logic [HIST_W-1:0]   bal_cnt_q [NUM_SPEC];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en) begin
			rd_data_s1 <= mem[req.rd_addr];
			fwd_val_s1 <= req.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			for (int k = 0; k < NUM_SPEC; k++)
				bal_cnt_q[k] <= '0;
		end else begin
			if (req.rd_en) begin
				vld_s1 <= vld_q[req.rd_addr];
				fwd_s1 <= req.we && (req.wr_addr == req.rd_addr);
			end
			if (req.we) begin
				vld_q[req.wr_addr] <= 1'b1;
				for (int k = 0; k < NUM_SPEC; k++)
					if (req.wr_addr == SPEC_CHARS[k])
						bal_cnt_q[k] <= req.wr_data;
			end
		end
	end

	// write in the read cycle returns the new value
	assign count = fwd_s1 ? fwd_val_s1 : (vld_s1 ? rd_data_s1 : '0);

	assign unbalanced = {
		bal_cnt_q[SP_LCUR] != bal_cnt_q[SP_RCUR],
		bal_cnt_q[SP_QUOTE][0],
		bal_cnt_q[SP_LPAR] != bal_cnt_q[SP_RPAR],
		bal_cnt_q[SP_LSQ] != bal_cnt_q[SP_RSQ]
	};

endmodule

`default_nettype wire

### rtl/lexer_input_buffer_with_histogram.sv
// ----------------------------------------------------------------------------
// Lexer input buffer with histogram
// Command-driven character buffer for a lexer: add, get, retract, mark and
// restore, recover, clear, and histogram query.
// Input channel (in_valid/in_stall) carries cmd, data_byte, mark_position;
// output channel (out_valid/out_stall) carries one result per item.
// An item is registered on accept and its result on advance to the output
// register; one item per cycle sustained while the output is not stalled. The
// store is touched at most once per item; the histogram is read on accept and
// written on advance of an add. A stalled result holds the output register
// and the item behind it; in_stall rises only when both are occupied and the
// output is stalled. fill_limit is written through cfg_valid/cfg_ready, always
// ready; the user must write it only while idle, which the block does not
// enforce. Reset clears positions, flags, counters, checksum and histogram
// valid bits; no clearing pass is needed; items are taken right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lexer_input_buffer_with_histogram_defines.svh"

module lexer_input_buffer_with_histogram
	import libh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              cfg_valid,
	output      logic              cfg_ready,
	input  wire logic [POS_W-1:0]  fill_limit,

	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [2:0]        cmd,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [POS_W-1:0]  mark_position,

	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic              ok,
	output      logic [CHAR_W-1:0] char_out,
	output      logic              at_end,
	output      logic [POS_W-1:0]  read_pos,
	output      logic [POS_W-1:0]  write_pos,
	output      logic [POS_W-1:0]  mark_pos,
	output      logic              is_empty,
	output      logic              is_full,
	output      logic [ERR_W-1:0]  error_count,
	output      logic [HIST_W-1:0] char_count,
	output      logic [SUM_W-1:0]  checksum,
	output      logic [BAL_W-1:0]  unbalanced
);

	logic [POS_W-1:0]  fill_q;
	logic [POS_W-1:0]  rd_q, wr_q, mark_q;
	logic              empty_q, end_q;
	logic [ERR_W-1:0]  err_q;
	logic [SUM_W-1:0]  sum_q;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [POS_W-1:0]  markp_s1;

	logic              valid_s2;
	cmd_t              cmd_s2;
	logic              ok_s2;
	logic              char_en_s2;
	logic [HIST_W-1:0] count_s2;

	logic              adv, in_acc;
	logic [POS_W-1:0]  lim;
	logic              full;
	logic [HIST_W-1:0] hist_count;
	logic [CHAR_W-1:0] store_rdata;
	hist_req_t         hist_req;
	store_req_t        store_req;

	logic [POS_W-1:0]  rd_d, wr_d, mark_d;
	logic              empty_d, end_d;
	logic [ERR_W-1:0]  err_d;
	logic [SUM_W-1:0]  sum_d;
	logic              ok_d, char_en_d, add_d, get_d;
	logic [HIST_W-1:0] count_d;

	// handshake
	assign adv       = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// effective fill limit, clamped to 1..CAPACITY
	always_comb begin
		if (fill_q > POS_W'(CAPACITY))
			lim = POS_W'(CAPACITY);
		else if (fill_q == '0)
			lim = POS_W'(1);
		else
			lim = fill_q;
	end

	assign full = ({1'b0, wr_q} + (POS_W+1)'(1)) >= {1'b0, lim};

	always_comb begin
		rd_d      = rd_q;
		wr_d      = wr_q;
		mark_d    = mark_q;
		empty_d   = empty_q;
		end_d     = end_q;
		err_d     = err_q;
		sum_d     = sum_q;
		ok_d      = 1'b0;
		char_en_d = 1'b0;
		add_d     = 1'b0;
		get_d     = 1'b0;
		count_d   = '0;
		unique case (cmd_s1)
			CMD_ADD: begin
				if (full) begin
					ok_d = 1'b0;
				end else if (byte_s1[BYTE_W-1]) begin
					if (err_q != ERR_MAX)
						err_d = err_q + ERR_W'(1);
				end else begin
					add_d   = 1'b1;
					wr_d    = wr_q + POS_W'(1);
					sum_d   = sum_q + SUM_W'(byte_s1[CHAR_W-1:0]);
					empty_d = 1'b0;
					ok_d    = 1'b1;
				end
			end
			CMD_GET: begin
				if (rd_q >= wr_q) begin
					end_d = 1'b1;
				end else begin
					end_d     = 1'b0;
					get_d     = 1'b1;
					char_en_d = 1'b1;
					rd_d      = rd_q + POS_W'(1);
					ok_d      = 1'b1;
				end
			end
			CMD_RETRACT: begin
				if (rd_q != '0) begin
					rd_d = rd_q - POS_W'(1);
					ok_d = 1'b1;
				end
			end
			CMD_RESTORE: begin
				rd_d = mark_q;
				ok_d = 1'b1;
			end
			CMD_SETMARK: begin
				if (markp_s1 <= wr_q) begin
					mark_d = markp_s1;
					ok_d   = 1'b1;
				end
			end
			CMD_RECOVER: begin
				rd_d   = '0;
				mark_d = '0;
				ok_d   = 1'b1;
			end
			CMD_CLEAR: begin
				rd_d    = '0;
				wr_d    = '0;
				empty_d = 1'b1;
				end_d   = 1'b0;
				ok_d    = 1'b1;
			end
			CMD_QUERY: begin
				if (!byte_s1[BYTE_W-1]) begin
					count_d = hist_count;
					ok_d    = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		hist_req.rd_en   = in_acc;
		hist_req.rd_addr = data_byte[CHAR_W-1:0];
		hist_req.we      = adv && add_d;
		hist_req.wr_addr = byte_s1[CHAR_W-1:0];
		hist_req.wr_data = (hist_count == HIST_MAX) ? hist_count
			: hist_count + HIST_W'(1);

		store_req.we    = adv && add_d;
		store_req.waddr = wr_q[ADDR_W-1:0];
		store_req.wdata = byte_s1[CHAR_W-1:0];
		store_req.re    = adv && get_d;
		store_req.raddr = rd_q[ADDR_W-1:0];
	end

	libh_hist u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (hist_req),
		.count      (hist_count),
		.unbalanced (unbalanced)
	);

	libh_store u_store (
		.clk   (clk),
		.req   (store_req),
		.rdata (store_rdata)
	);

	// control state and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= FILL_RESET;
			rd_q     <= '0;
			wr_q     <= '0;
			mark_q   <= '0;
			empty_q  <= 1'b1;
			end_q    <= 1'b0;
			err_q    <= '0;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				fill_q <= fill_limit;
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
			if (adv) begin
				rd_q    <= rd_d;
				wr_q    <= wr_d;
				mark_q  <= mark_d;
				empty_q <= empty_d;
				end_q   <= end_d;
				err_q   <= err_d;
				sum_q   <= sum_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= cmd_t'(cmd);
			byte_s1  <= data_byte;
			markp_s1 <= mark_position;
		end
		if (adv) begin
			cmd_s2     <= cmd_s1;
			ok_s2      <= ok_d;
			char_en_s2 <= char_en_d;
			count_s2   <= count_d;
		end
	end

	assign out_valid   = valid_s2;
	assign ok          = ok_s2;
	assign char_out    = char_en_s2 ? store_rdata : '0;
	assign at_end      = end_q;
	assign read_pos    = rd_q;
	assign write_pos   = wr_q;
	assign mark_pos    = mark_q;
	assign is_empty    = empty_q;
	assign is_full     = full;
	assign error_count = err_q;
	assign char_count  = count_s2;
	assign checksum    = sum_q;

	`LIBH_ASSERT_IMP(a_get_ok_vs_end, valid_s2 && cmd_s2 == CMD_GET, ok_s2 == !end_q)
	`LIBH_ASSERT_IMP(a_count_query_only, valid_s2 && cmd_s2 != CMD_QUERY, count_s2 == '0)
	`LIBH_ASSERT_ALW(a_wr_in_range, wr_q < POS_W'(CAPACITY))
	`LIBH_ASSERT_NXT(a_adv_fills_out, adv, valid_s2)

endmodule

`default_nettype wire

### test/lexer_buffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer buffer result checker
// Watches the config, command and result channels of the lexer input buffer.
// It keeps its own copy of the buffer, histogram and counters and works out
// the result of every accepted command. Each accepted result is compared
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module lexer_buffer_checker
	import libh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [POS_W-1:0]  fill_limit,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [2:0]        cmd,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [POS_W-1:0]  mark_position,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic              ok,
	input  wire logic [CHAR_W-1:0] char_out,
	input  wire logic              at_end,
	input  wire logic [POS_W-1:0]  read_pos,
	input  wire logic [POS_W-1:0]  write_pos,
	input  wire logic [POS_W-1:0]  mark_pos,
	input  wire logic              is_empty,
	input  wire logic              is_full,
	input  wire logic [ERR_W-1:0]  error_count,
	input  wire logic [HIST_W-1:0] char_count,
	input  wire logic [SUM_W-1:0]  checksum,
	input  wire logic [BAL_W-1:0]  unbalanced,
	output int                     mismatches,
	output int                     pending
);

	localparam logic [CHAR_W-1:0] CH_LSQ   = 7'h5B;
	localparam logic [CHAR_W-1:0] CH_RSQ   = 7'h5D;
	localparam logic [CHAR_W-1:0] CH_LPAR  = 7'h28;
	localparam logic [CHAR_W-1:0] CH_RPAR  = 7'h29;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 7'h22;
	localparam logic [CHAR_W-1:0] CH_LCUR  = 7'h7B;
	localparam logic [CHAR_W-1:0] CH_RCUR  = 7'h7D;

	typedef struct packed {
		logic              ok;
		logic [CHAR_W-1:0] ch;
		logic              at_end;
		logic [POS_W-1:0]  rd;
		logic [POS_W-1:0]  wr;
		logic [POS_W-1:0]  mk;
		logic              empty;
		logic              full;
		logic [ERR_W-1:0]  errs;
		logic [HIST_W-1:0] count;
		logic [SUM_W-1:0]  sum;
		logic [BAL_W-1:0]  bal;
	} buf_result_t;

	buf_result_t       expected_results [$];
	buf_result_t       want;
	buf_result_t       got;
	logic [CHAR_W-1:0] char_copy [CAPACITY];
	logic [HIST_W-1:0] char_tally [ALPHABET];
	logic [POS_W-1:0]  rd_idx;
	logic [POS_W-1:0]  wr_idx;
	logic [POS_W-1:0]  mk_idx;
	logic [POS_W-1:0]  limit_reg;
	logic              empty_now;
	logic              end_now;
	logic [ERR_W-1:0]  refused;
	logic [SUM_W-1:0]  sum_now;
	int                results_seen;

	function automatic int clamped_limit();
		int lim;
		lim = int'(limit_reg);
		if (lim > CAPACITY) lim = CAPACITY;
		if (lim < 1) lim = 1;
		return lim;
	endfunction

	function automatic logic [BAL_W-1:0] balance_bits();
		logic [BAL_W-1:0] f;
		f[0] = char_tally[CH_LSQ] != char_tally[CH_RSQ];
		f[1] = char_tally[CH_LPAR] != char_tally[CH_RPAR];
		f[2] = char_tally[CH_QUOTE][0];
		f[3] = char_tally[CH_LCUR] != char_tally[CH_RCUR];
		return f;
	endfunction

	task automatic run_command(input cmd_t c, input logic [BYTE_W-1:0] b,
			input logic [POS_W-1:0] m);
		buf_result_t r;
		r = '0;
		case (c)
			CMD_ADD: begin
				// full check comes first and is not an error
				if (int'(wr_idx) + 1 < clamped_limit()) begin
					if (b >= ALPHABET) begin
						if (refused != ERR_MAX) refused = refused + 1'b1;
					end else begin
						char_copy[wr_idx[ADDR_W-1:0]] = b[CHAR_W-1:0];
						wr_idx = wr_idx + 1'b1;
						if (char_tally[b[CHAR_W-1:0]] != HIST_MAX)
							char_tally[b[CHAR_W-1:0]] = char_tally[b[CHAR_W-1:0]] + 1'b1;
						sum_now = sum_now + SUM_W'(b);
						empty_now = 1'b0;
						r.ok = 1'b1;
					end
				end
			end
			CMD_GET: begin
				if (rd_idx >= wr_idx || int'(rd_idx) >= CAPACITY) begin
					end_now = 1'b1;
				end else begin
					end_now = 1'b0;
					r.ch = char_copy[rd_idx[ADDR_W-1:0]];
					rd_idx = rd_idx + 1'b1;
					r.ok = 1'b1;
				end
			end
			CMD_RETRACT: begin
				if (rd_idx != '0) begin
					rd_idx = rd_idx - 1'b1;
					r.ok = 1'b1;
				end
			end
			CMD_RESTORE: begin
				rd_idx = mk_idx;
				r.ok = 1'b1;
			end
			CMD_SETMARK: begin
				if (m <= wr_idx) begin
					mk_idx = m;
					r.ok = 1'b1;
				end
			end
			CMD_RECOVER: begin
				rd_idx = '0;
				mk_idx = '0;
				r.ok = 1'b1;
			end
			CMD_CLEAR: begin
				rd_idx = '0;
				wr_idx = '0;
				empty_now = 1'b1;
				end_now = 1'b0;
				r.ok = 1'b1;
			end
			default: begin
				if (b < ALPHABET) begin
					r.count = char_tally[b[CHAR_W-1:0]];
					r.ok = 1'b1;
				end
			end
		endcase
		r.at_end = end_now;
		r.rd = rd_idx;
		r.wr = wr_idx;
		r.mk = mk_idx;
		r.empty = empty_now;
		r.full = int'(wr_idx) + 1 >= clamped_limit();
		r.errs = refused;
		r.sum = sum_now;
		r.bal = balance_bits();
		expected_results.push_back(r);
	endtask

	task automatic check_field(input string label, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected 0x%0h, got 0x%0h",
					results_seen, label, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			foreach (char_tally[i]) char_tally[i] = '0;
			rd_idx = '0;
			wr_idx = '0;
			mk_idx = '0;
			limit_reg = FILL_RESET;
			empty_now = 1'b1;
			end_now = 1'b0;
			refused = '0;
			sum_now = '0;
			results_seen = 0;
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) limit_reg = fill_limit;
			if (out_valid && !out_stall) begin
				got = '{ok, char_out, at_end, read_pos, write_pos, mark_pos, is_empty,
					is_full, error_count, char_count, checksum, unbalanced};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: no result was due", results_seen);
				end else begin
					want = expected_results.pop_front();
					check_field("ok", 32'(want.ok), 32'(got.ok));
					check_field("char_out", 32'(want.ch), 32'(got.ch));
					check_field("at_end", 32'(want.at_end), 32'(got.at_end));
					check_field("read_pos", 32'(want.rd), 32'(got.rd));
					check_field("write_pos", 32'(want.wr), 32'(got.wr));
					check_field("mark_pos", 32'(want.mk), 32'(got.mk));
					check_field("is_empty", 32'(want.empty), 32'(got.empty));
					check_field("is_full", 32'(want.full), 32'(got.full));
					check_field("error_count", 32'(want.errs), 32'(got.errs));
					check_field("char_count", 32'(want.count), 32'(got.count));
					check_field("checksum", want.sum, got.sum);
					check_field("unbalanced", 32'(want.bal), 32'(got.bal));
				end
				results_seen++;
			end
			if (in_valid && !in_stall)
				run_command(cmd_t'(cmd), data_byte, mark_position);
			pending <= expected_results.size();
		end
	end

endmodule

### test/tb_lexer_input_buffer_with_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer input buffer testbench
// Drives command items and fill limit writes into the lexer input buffer,
// with random idle bursts on both channels, and leaves the prediction and
// comparison of every result to the checker. A directed run over the special
// cases is followed by random phases at several fill limits.
// ----------------------------------------------------------------------------
module tb_lexer_input_buffer_with_histogram;
	import libh_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 50;
	localparam logic [POS_W-1:0] PHASE_LIMITS [PHASES] = '{
		13'd2, 13'd1, 13'd0, 13'd8191, 13'd7, 13'd4096, 13'd23, 13'd3, 13'd12
	};
	localparam logic [BYTE_W-1:0] PUNCT [7] = '{
		8'h5B, 8'h5D, 8'h28, 8'h29, 8'h22, 8'h7B, 8'h7D
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [POS_W-1:0]  fill_limit;
	logic              in_valid;
	logic              in_stall;
	cmd_t              cmd;
	logic [BYTE_W-1:0] data_byte;
	logic [POS_W-1:0]  mark_position;
	logic              out_valid;
	logic              out_stall;
	logic              ok;
	logic [CHAR_W-1:0] char_out;
	logic              at_end;
	logic [POS_W-1:0]  read_pos;
	logic [POS_W-1:0]  write_pos;
	logic [POS_W-1:0]  mark_pos;
	logic              is_empty;
	logic              is_full;
	logic [ERR_W-1:0]  error_count;
	logic [HIST_W-1:0] char_count;
	logic [SUM_W-1:0]  checksum;
	logic [BAL_W-1:0]  unbalanced;
	int                mismatches;
	int                pending;
	int                cycle_count = 0;
	bit                calm = 1'b0;

	lexer_input_buffer_with_histogram uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .fill_limit(fill_limit),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.data_byte(data_byte), .mark_position(mark_position),
		.out_valid(out_valid), .out_stall(out_stall), .ok(ok),
		.char_out(char_out), .at_end(at_end), .read_pos(read_pos),
		.write_pos(write_pos), .mark_pos(mark_pos), .is_empty(is_empty),
		.is_full(is_full), .error_count(error_count), .char_count(char_count),
		.checksum(checksum), .unbalanced(unbalanced)
	);

	lexer_buffer_checker result_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .fill_limit(fill_limit),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.data_byte(data_byte), .mark_position(mark_position),
		.out_valid(out_valid), .out_stall(out_stall), .ok(ok),
		.char_out(char_out), .at_end(at_end), .read_pos(read_pos),
		.write_pos(write_pos), .mark_pos(mark_pos), .is_empty(is_empty),
		.is_full(is_full), .error_count(error_count), .char_count(char_count),
		.checksum(checksum), .unbalanced(unbalanced),
		.mismatches(mismatches), .pending(pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		forever begin
			if (calm || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input cmd_t c, input logic [BYTE_W-1:0] b,
			input logic [POS_W-1:0] m);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		data_byte <= b;
		mark_position <= m;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_fill_limit(input logic [POS_W-1:0] v);
		cfg_valid <= 1'b1;
		fill_limit <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] pick_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return PUNCT[$urandom_range(0, 6)];
		if (r < 9) return BYTE_W'($urandom_range(0, 127));
		return BYTE_W'($urandom_range(128, 255));
	endfunction

	task automatic send_random();
		int w;
		logic [BYTE_W-1:0] junk;
		logic [POS_W-1:0] m;
		w = $urandom_range(0, 99);
		junk = BYTE_W'($urandom_range(0, 255));
		m = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 8191))
			: POS_W'($urandom_range(0, 48));
		if (w < 42) send_item(CMD_ADD, pick_char(), m);
		else if (w < 66) send_item(CMD_GET, junk, m);
		else if (w < 72) send_item(CMD_RETRACT, junk, m);
		else if (w < 77) send_item(CMD_RESTORE, junk, m);
		else if (w < 85) send_item(CMD_SETMARK, junk, m);
		else if (w < 89) send_item(CMD_RECOVER, junk, m);
		else if (w < 92) send_item(CMD_CLEAR, junk, m);
		else send_item(CMD_QUERY, ($urandom_range(0, 2) == 0) ? junk : pick_char(), m);
	endtask

	initial begin
		int p;
		int n;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		fill_limit <= FILL_RESET;
		in_valid <= 1'b0;
		cmd <= CMD_ADD;
		data_byte <= '0;
		mark_position <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_item(CMD_ADD, 8'h00, 13'd0);
		send_item(CMD_ADD, 8'h7F, 13'd0);
		send_item(CMD_ADD, 8'h80, 13'd0);
		send_item(CMD_ADD, 8'hFF, 13'd0);
		send_item(CMD_ADD, 8'h5B, 13'd0);
		send_item(CMD_ADD, 8'h28, 13'd0);
		send_item(CMD_ADD, 8'h22, 13'd0);
		send_item(CMD_ADD, 8'h7B, 13'd0);
		send_item(CMD_SETMARK, 8'h00, 13'h1FFF);
		send_item(CMD_SETMARK, 8'h00, 13'd5);
		send_item(CMD_GET, 8'h00, 13'd0);
		send_item(CMD_GET, 8'h00, 13'd0);
		send_item(CMD_RETRACT, 8'h00, 13'd0);
		send_item(CMD_RESTORE, 8'h00, 13'd0);
		send_item(CMD_GET, 8'h00, 13'd0);
		send_item(CMD_GET, 8'h00, 13'd0);
		send_item(CMD_RECOVER, 8'h00, 13'd0);
		send_item(CMD_RETRACT, 8'h00, 13'd0);
		send_item(CMD_QUERY, 8'h7F, 13'd0);
		send_item(CMD_QUERY, 8'h80, 13'd0);
		send_item(CMD_QUERY, 8'hFF, 13'd0);
		send_item(CMD_SETMARK, 8'h00, 13'd6);
		send_item(CMD_CLEAR, 8'h00, 13'd0);
		// mark now lies beyond the cleared write position
		send_item(CMD_RESTORE, 8'h00, 13'd0);
		send_item(CMD_GET, 8'h00, 13'd0);

		for (p = 0; p < PHASES; p++) begin
			drain_results();
			write_fill_limit(PHASE_LIMITS[p]);
			calm = (p == PHASES - 1);
			for (n = 0; n < ITEMS_PER_PHASE; n++) send_random();
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
